>>> design/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Sizes, the box record, controller states, and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 12;
	localparam int SCORE_BITS = 16;
	localparam int LABEL_BITS = 8;
	localparam int THR_BITS   = 16;

	localparam int IDX_W  = $clog2(MAX_BOXES);
	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int EXT_W  = COORD_BITS + 1;
	localparam int AREA_W = 2 * EXT_W;
	localparam int UNI_W  = AREA_W + 1;
	localparam int PROD_W = UNI_W + THR_BITS;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(29491);

	// Word index of the threshold register.
	localparam logic REG_THR = 1'b0;

	typedef struct packed {
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
		logic [COORD_BITS-1:0] x2;
		logic [COORD_BITS-1:0] y2;
		logic [SCORE_BITS-1:0] score;
		logic [LABEL_BITS-1:0] label;
	} box_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_PIV,
		ST_SORT_RUN,
		ST_SORT_WR,
		ST_NMS_CHK,
		ST_NMS_PIV,
		ST_NMS_AREA,
		ST_NMS_RUN,
		ST_EMIT_CHK,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic load;
		logic sort_init;
		logic sort_rd;
		logic sort_piv;
		logic sort_run;
		logic sort_wr;
		logic nms_init;
		logic nms_rd;
		logic nms_piv;
		logic nms_area;
		logic nms_run;
		logic nms_next;
		logic emit_init;
		logic emit_skip;
		logic emit_rd;
		logic emit_ld;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last_in;
		logic i_done;
		logic j_done;
		logic pipe_empty;
		logic kept_i;
		logic out_free;
	} stat_t;

	// Inclusive pixel extent; an inverted span counts as zero.
	function automatic logic [EXT_W-1:0] ext(input logic [COORD_BITS-1:0] lo,
			input logic [COORD_BITS-1:0] hi);
		logic [EXT_W-1:0] r;
		r = '0;
		if (hi >= lo) begin
			r = EXT_W'(hi) - EXT_W'(lo) + EXT_W'(1);
		end
		return r;
	endfunction

endpackage

>>> design/gbs_box_if.sv
// ----------------------------------------------------------------------------
// gbs_box_if: input channel carrying one detection box per beat
// Valid/ready handshake with the box corners, score, label and set marker.
// ----------------------------------------------------------------------------
interface gbs_box_if import gbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] box_x1;
	logic [COORD_BITS-1:0] box_y1;
	logic [COORD_BITS-1:0] box_x2;
	logic [COORD_BITS-1:0] box_y2;
	logic [SCORE_BITS-1:0] box_score;
	logic [LABEL_BITS-1:0] box_label;
	logic                  is_last;

	modport source (output valid, box_x1, box_y1, box_x2, box_y2, box_score, box_label,
		is_last, input ready);
	modport sink (input valid, box_x1, box_y1, box_x2, box_y2, box_score, box_label,
		is_last, output ready);
endinterface

>>> design/gbs_res_if.sv
// ----------------------------------------------------------------------------
// gbs_res_if: output channel carrying one surviving box per beat
// Valid/ready handshake with the box fields, set end marker and overflow flag.
// ----------------------------------------------------------------------------
interface gbs_res_if import gbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] out_x1;
	logic [COORD_BITS-1:0] out_y1;
	logic [COORD_BITS-1:0] out_x2;
	logic [COORD_BITS-1:0] out_y2;
	logic [SCORE_BITS-1:0] out_score;
	logic [LABEL_BITS-1:0] out_label;
	logic                  out_last;
	logic                  overflow;

	modport source (output valid, out_x1, out_y1, out_x2, out_y2, out_score, out_label,
		out_last, overflow, input ready);
	modport sink (input valid, out_x1, out_y1, out_x2, out_y2, out_score, out_label,
		out_last, overflow, output ready);
endinterface

>>> design/gbs_ctrl.sv
// ----------------------------------------------------------------------------
// gbs_ctrl: sequencing state machine
// Steps through load, rank sort, suppression and emission, issuing one
// command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module gbs_ctrl import gbs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stat_t  stat,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.last_in) begin
						cmd.sort_init = 1'b1;
						state_d       = ST_SORT_RD;
					end
				end
			end
			ST_SORT_RD: begin
				if (stat.i_done) begin
					cmd.nms_init = 1'b1;
					state_d      = ST_NMS_CHK;
				end else begin
					cmd.sort_rd = 1'b1;
					state_d     = ST_SORT_PIV;
				end
			end
			ST_SORT_PIV: begin
				cmd.sort_piv = 1'b1;
				state_d      = ST_SORT_RUN;
			end
			ST_SORT_RUN: begin
				cmd.sort_run = 1'b1;
				if (stat.j_done && stat.pipe_empty) begin
					state_d = ST_SORT_WR;
				end
			end
			ST_SORT_WR: begin
				cmd.sort_wr = 1'b1;
				state_d     = ST_SORT_RD;
			end
			ST_NMS_CHK: begin
				if (stat.i_done) begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT_CHK;
				end else if (!stat.kept_i) begin
					cmd.nms_next = 1'b1;
				end else begin
					cmd.nms_rd = 1'b1;
					state_d    = ST_NMS_PIV;
				end
			end
			ST_NMS_PIV: begin
				cmd.nms_piv = 1'b1;
				state_d     = ST_NMS_AREA;
			end
			ST_NMS_AREA: begin
				cmd.nms_area = 1'b1;
				state_d      = ST_NMS_RUN;
			end
			ST_NMS_RUN: begin
				cmd.nms_run = 1'b1;
				if (stat.j_done && stat.pipe_empty) begin
					cmd.nms_next = 1'b1;
					state_d      = ST_NMS_CHK;
				end
			end
			ST_EMIT_CHK: begin
				if (stat.i_done) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end else if (!stat.kept_i) begin
					cmd.emit_skip = 1'b1;
				end else if (stat.out_free) begin
					cmd.emit_rd = 1'b1;
					state_d     = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				state_d     = ST_EMIT_CHK;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

>>> design/gbs_dpath.sv
// ----------------------------------------------------------------------------
// gbs_dpath: box stores, rank sort, overlap pipeline and output register
// Holds the loaded and the score-ordered box memories, the counters, the
// kept mask and the five-stage IoU test.
// ----------------------------------------------------------------------------
module gbs_dpath import gbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [THR_BITS-1:0] thr,
	input  box_t                in_box,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output box_t                out_box,
	output logic                out_last,
	output logic                out_ovf
);

	box_t box_mem  [MAX_BOXES];
	box_t sort_mem [MAX_BOXES];
	box_t box_rd_q, sort_rd_q, piv_q;

	logic [CNT_W-1:0]     count_q, i_q, j_q, cnt_q, rd_idx_q;
	logic                 ovf_q;
	logic [MAX_BOXES-1:0] kept_q;
	logic                 cnt_v_q, cmp_v_q;
	logic [AREA_W-1:0]    area_a_q;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3, idx_s4;
	logic [EXT_W-1:0]     ix_s1, iy_s1, bw_s1, bh_s1;
	logic [AREA_W-1:0]    inter_s2, areab_s2, inter_s3, inter_s4;
	logic [UNI_W-1:0]     uni_s3;
	logic [PROD_W-1:0]    prod_s4;
	logic                 zero_s4;

	logic                 out_v_q, out_last_q, out_ovf_q;
	box_t                 out_box_q;

	logic                 issue, j_done, beats, suppress, more;
	logic [CNT_W-1:0]     box_addr, sort_addr;
	logic [COORD_BITS-1:0] lx, ly, hx, hy;
	logic [EXT_W-1:0]     ix, iy, bw, bh;
	logic [MAX_BOXES-1:0] above;

	assign j_done    = (j_q == count_q);
	assign issue     = (cmd.sort_run || cmd.nms_run) && !j_done;
	assign box_addr  = cmd.sort_run ? j_q : i_q;
	assign sort_addr = cmd.nms_run ? j_q : i_q;

	// Box memory: written on load, read by the sort.
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CNT_W'(MAX_BOXES))) begin
			box_mem[count_q[IDX_W-1:0]] <= in_box;
		end
		box_rd_q <= box_mem[box_addr[IDX_W-1:0]];
	end

	// Score-ordered memory: written by the sort, read by suppression and emission.
	always_ff @(posedge clk) begin
		if (cmd.sort_wr) begin
			sort_mem[cnt_q[IDX_W-1:0]] <= piv_q;
		end
		sort_rd_q <= sort_mem[sort_addr[IDX_W-1:0]];
	end

	// A box ranks ahead of the pivot on a higher score, or an equal one loaded earlier.
	assign beats = (box_rd_q.score > piv_q.score) ||
		((box_rd_q.score == piv_q.score) && (rd_idx_q < i_q));

	always_comb begin
		lx = (piv_q.x1 > sort_rd_q.x1) ? piv_q.x1 : sort_rd_q.x1;
		ly = (piv_q.y1 > sort_rd_q.y1) ? piv_q.y1 : sort_rd_q.y1;
		hx = (piv_q.x2 < sort_rd_q.x2) ? piv_q.x2 : sort_rd_q.x2;
		hy = (piv_q.y2 < sort_rd_q.y2) ? piv_q.y2 : sort_rd_q.y2;
		ix = ext(lx, hx);
		iy = ext(ly, hy);
		bw = ext(sort_rd_q.x1, sort_rd_q.x2);
		bh = ext(sort_rd_q.y1, sort_rd_q.y2);
	end

	assign suppress = v_s4 && !zero_s4 &&
		(PROD_W'({inter_s4, THR_BITS'(0)}) >= prod_s4);

	always_comb begin
		for (int e = 0; e < MAX_BOXES; e++) begin
			above[e] = kept_q[e] && (CNT_W'(e) > i_q) && (CNT_W'(e) < count_q);
		end
		more = |above;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			kept_q  <= '1;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
			cnt_v_q <= 1'b0;
			cmp_v_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (count_q < CNT_W'(MAX_BOXES)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.sort_init || cmd.nms_init || cmd.emit_init) begin
				i_q <= '0;
			end else if (cmd.sort_wr || cmd.nms_next || cmd.emit_skip || cmd.emit_ld) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (cmd.sort_piv) begin
				j_q <= '0;
			end else if (cmd.nms_piv) begin
				j_q <= i_q + CNT_W'(1);
			end else if (issue) begin
				j_q <= j_q + CNT_W'(1);
			end
			if (cmd.sort_piv) begin
				cnt_q <= '0;
			end else if (cnt_v_q && beats) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			cnt_v_q <= issue && cmd.sort_run;
			cmp_v_q <= issue && cmd.nms_run;
			v_s1    <= cmp_v_q;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (cmd.finish) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				kept_q  <= '1;
			end else if (suppress) begin
				kept_q[idx_s4] <= 1'b0;
			end
			if (cmd.emit_ld) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers of the sort, the overlap pipeline and the output.
	always_ff @(posedge clk) begin
		rd_idx_q <= j_q;
		if (cmd.sort_piv) begin
			piv_q <= box_rd_q;
		end else if (cmd.nms_piv) begin
			piv_q <= sort_rd_q;
		end
		if (cmd.nms_area) begin
			area_a_q <= AREA_W'(ext(piv_q.x1, piv_q.x2)) * AREA_W'(ext(piv_q.y1, piv_q.y2));
		end
		idx_s1   <= rd_idx_q[IDX_W-1:0];
		ix_s1    <= ix;
		iy_s1    <= iy;
		bw_s1    <= bw;
		bh_s1    <= bh;
		idx_s2   <= idx_s1;
		inter_s2 <= AREA_W'(ix_s1) * AREA_W'(iy_s1);
		areab_s2 <= AREA_W'(bw_s1) * AREA_W'(bh_s1);
		idx_s3   <= idx_s2;
		inter_s3 <= inter_s2;
		uni_s3   <= UNI_W'(area_a_q) + UNI_W'(areab_s2) - UNI_W'(inter_s2);
		idx_s4   <= idx_s3;
		inter_s4 <= inter_s3;
		zero_s4  <= (uni_s3 == '0);
		prod_s4  <= PROD_W'(thr) * PROD_W'(uni_s3);
		if (cmd.emit_ld) begin
			out_box_q  <= sort_rd_q;
			out_last_q <= !more;
			out_ovf_q  <= ovf_q;
		end
	end

	assign stat.last_in    = in_last;
	assign stat.i_done     = (i_q == count_q);
	assign stat.j_done     = j_done;
	assign stat.pipe_empty = !(cnt_v_q || cmp_v_q || v_s1 || v_s2 || v_s3 || v_s4);
	assign stat.kept_i     = kept_q[i_q[IDX_W-1:0]];
	assign stat.out_free   = !out_v_q || out_ready;

	assign out_valid = out_v_q;
	assign out_box   = out_box_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule

>>> design/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression: greedy non-maximum suppression over one box set
// Loads boxes, ranks them by score and drops overlapping lower-ranked boxes.
// ----------------------------------------------------------------------------
// Boxes arrive on the boxes channel, one per beat, at one beat per cycle while
// the block is loading. The beat marked is_last closes the set; boxes beyond
// the store capacity are dropped and every result of that set carries overflow.
// After the last beat ready stays low while the set is processed.
// Ranking counts, for each of the n stored boxes, how many boxes beat it, one
// box memory read per cycle. Suppression then walks the ranked memory; each
// kept box is compared against every lower-ranked box through a five-stage
// IoU pipeline that drains before the next kept box is taken. Each box
// memory has a single read port. Survivors then leave on the survivors
// channel in rank order, dropped boxes being skipped, the final one with
// out_last.
// A stalled receiver holds the output register and pauses emission; the last
// survivor may still wait there while the next set is already loading.
// The threshold register sits at APB address 0; the user writes it while idle, not enforced by the block.
// Reset empties the set, clears overflow, marks all boxes kept and sets the
// threshold to 0.45 in Q0.16; box memories are not cleared.
// ----------------------------------------------------------------------------
module greedy_box_suppression import gbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	gbs_box_if.sink            boxes,
	gbs_res_if.source          survivors,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [THR_BITS-1:0] thr_q;
	cmd_t                cmd;
	stat_t               stat;
	box_t                in_box, out_box;

	// Configuration: the threshold is the only register, decoded on the word index.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_THR)) begin
			thr_q <= pwdata[THR_BITS-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_THR) ? PDATA_W'(thr_q) : '0;

	// Gather the input fields into one box record.
	assign in_box.x1    = boxes.box_x1;
	assign in_box.y1    = boxes.box_y1;
	assign in_box.x2    = boxes.box_x2;
	assign in_box.y2    = boxes.box_y2;
	assign in_box.score = boxes.box_score;
	assign in_box.label = boxes.box_label;

	gbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (boxes.valid),
		.in_ready (boxes.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.thr       (thr_q),
		.in_box    (in_box),
		.in_last   (boxes.is_last),
		.out_valid (survivors.valid),
		.out_ready (survivors.ready),
		.out_box   (out_box),
		.out_last  (survivors.out_last),
		.out_ovf   (survivors.overflow)
	);

	assign survivors.out_x1    = out_box.x1;
	assign survivors.out_y1    = out_box.y1;
	assign survivors.out_x2    = out_box.x2;
	assign survivors.out_y2    = out_box.y2;
	assign survivors.out_score = out_box.score;
	assign survivors.out_label = out_box.label;

	// The last beat of a set hands control to ranking, so loading stops at once.
	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		(boxes.valid && boxes.ready && boxes.is_last) |=> !boxes.ready)
		else $error("input still ready after the closing beat");

	// A survivor is only loaded into an empty output register.
	a_emit_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld |-> !survivors.valid)
		else $error("output register overwritten");

	// The overlap pipeline has drained before the next pivot is chosen.
	a_nms_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nms_next |-> stat.pipe_empty)
		else $error("suppression advanced with tests in flight");

	// A rank is written only after every score compare has landed.
	a_rank_final: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sort_wr |-> (stat.pipe_empty && stat.j_done))
		else $error("rank written before counting finished");

endmodule
